[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the pcm frame converter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pfsv_pkg.sv]
// ----------------------------------------------------------------------------
// pfsv_pkg
// Types, constants and helpers for the pcm frame to stereo16 converter
// ----------------------------------------------------------------------------
package pfsv_pkg;

	localparam int RAW_W      = 32;
	localparam int SAMPLE_W   = 16;
	localparam int VOL_W      = 7;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// signed gain product and its magnitude
	localparam int PROD_W = 24;
	localparam int MAG_W  = 23;

	localparam int U8_BIAS     = 128;
	localparam int PERCENT_DIV = 100;

	// divide by 100 as a multiply by a rounded-up reciprocal, exact for MAG_W bits
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 24;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + PERCENT_DIV - 1) / PERCENT_DIV;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int QUOT_W = MAG_W + RECIP_W - RECIP_SHIFT;

	localparam logic [QUOT_W-1:0] SAT_POS_LIMIT = QUOT_W'(32767);
	localparam logic [QUOT_W-1:0] SAT_NEG_LIMIT = QUOT_W'(32768);
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		WIDTH_U8  = 2'd0,
		WIDTH_S16 = 2'd1,
		WIDTH_S24 = 2'd2,
		WIDTH_S32 = 2'd3
	} width_code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SAMPLE_WIDTH = 2'd0,
		REG_MONO_SOURCE  = 2'd1,
		REG_GAIN_PCT     = 2'd2
	} reg_index_t;

	localparam logic [VOL_W-1:0] VOLUME_RESET = VOL_W'(60);

	typedef struct packed {
		width_code_t      width_code;
		logic             mono_source;
		logic [VOL_W-1:0] gain_pct;
	} pfsv_cfg_t;

	// input register contents
	typedef struct packed {
		logic [RAW_W-1:0] first_sample_raw;
		logic [RAW_W-1:0] second_sample_raw;
		logic             last_frame;
	} pfsv_s1_t;

	// gain product as sign and magnitude
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             last_frame;
	} pfsv_s2_t;

	// reduce one raw little-endian word to a signed 16-bit sample
	function automatic logic [SAMPLE_W-1:0] reduce_sample(
		input logic [RAW_W-1:0] raw,
		input width_code_t      code
	);
		logic [7:0] unbiased;
		logic [SAMPLE_W-1:0] res;
		unbiased = raw[7:0] - 8'(U8_BIAS);
		unique case (code)
			WIDTH_U8:  res = {unbiased, 8'h00};
			WIDTH_S16: res = raw[15:0];
			WIDTH_S24: res = raw[23:8];
			WIDTH_S32: res = raw[31:16];
			default:   res = raw[15:0];
		endcase
		return res;
	endfunction

endpackage

[hw/rtl/pfsv_if.sv]
// ----------------------------------------------------------------------------
// pfsv_if
// Valid/ready channel interfaces for frames, samples and register writes
// ----------------------------------------------------------------------------
interface pfsv_in_if;
	logic                          valid;
	logic                          ready;
	logic [pfsv_pkg::RAW_W-1:0]    first_sample_raw;
	logic [pfsv_pkg::RAW_W-1:0]    second_sample_raw;
	logic                          last_frame;

	modport source (output valid, first_sample_raw, second_sample_raw, last_frame,
		input ready);
	modport sink (input valid, first_sample_raw, second_sample_raw, last_frame,
		output ready);
endinterface

interface pfsv_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pfsv_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [pfsv_pkg::SAMPLE_W-1:0] right_sample;
	logic                                 last_frame_out;

	modport source (output valid, left_sample, right_sample, last_frame_out,
		input ready);
	modport sink (input valid, left_sample, right_sample, last_frame_out,
		output ready);
endinterface

interface pfsv_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pfsv_pkg::REG_IDX_W-1:0]    index;
	logic [pfsv_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/pfsv_gain.sv]
// ----------------------------------------------------------------------------
// pfsv_gain
// Sample reduction, channel averaging (or first sample in mono mode) and volume multiply into stage 2
// ----------------------------------------------------------------------------
module pfsv_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  pfsv_pkg::pfsv_cfg_t cfg_val,
	input  logic                up_valid,
	output logic                up_ready,
	input  pfsv_pkg::pfsv_s1_t  up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output pfsv_pkg::pfsv_s2_t  dn_data
);

	logic [pfsv_pkg::SAMPLE_W-1:0]        first_red;
	logic [pfsv_pkg::SAMPLE_W-1:0]        second_red;
	logic [pfsv_pkg::SAMPLE_W:0]          pair_sum;
	logic [pfsv_pkg::SAMPLE_W:0]          pair_adj;
	logic [pfsv_pkg::SAMPLE_W-1:0]        sample;
	logic signed [pfsv_pkg::PROD_W-1:0]   sample_ext;
	logic signed [pfsv_pkg::PROD_W-1:0]   vol_ext;
	logic signed [pfsv_pkg::PROD_W-1:0]   prod;
	logic [pfsv_pkg::PROD_W-1:0]          prod_abs;
	logic                                 valid_s2;
	pfsv_pkg::pfsv_s2_t                   data_s2;

	always_comb begin
		first_red  = pfsv_pkg::reduce_sample(up_data.first_sample_raw, cfg_val.width_code);
		second_red = pfsv_pkg::reduce_sample(up_data.second_sample_raw, cfg_val.width_code);
		pair_sum   = {first_red[pfsv_pkg::SAMPLE_W-1], first_red}
			+ {second_red[pfsv_pkg::SAMPLE_W-1], second_red};
		// add one before halving a negative sum so it truncates toward zero
		pair_adj   = pair_sum + (pfsv_pkg::SAMPLE_W+1)'(pair_sum[pfsv_pkg::SAMPLE_W]);
		sample     = cfg_val.mono_source ? first_red : pair_adj[pfsv_pkg::SAMPLE_W:1];
		sample_ext = $signed({{(pfsv_pkg::PROD_W-pfsv_pkg::SAMPLE_W){sample[pfsv_pkg::SAMPLE_W-1]}},
			sample});
		vol_ext    = $signed({{(pfsv_pkg::PROD_W-pfsv_pkg::VOL_W){1'b0}}, cfg_val.gain_pct});
		prod       = sample_ext * vol_ext;
		prod_abs   = prod[pfsv_pkg::PROD_W-1] ? (-prod) : prod;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2.neg        <= prod[pfsv_pkg::PROD_W-1];
			data_s2.mag        <= prod_abs[pfsv_pkg::MAG_W-1:0];
			data_s2.last_frame <= up_data.last_frame;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

[hw/rtl/pfsv_scale.sv]
// ----------------------------------------------------------------------------
// pfsv_scale
// Divide by one hundred, saturate to 16 bits and hold the result register
// ----------------------------------------------------------------------------
module pfsv_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  pfsv_pkg::pfsv_s2_t up_data,
	pfsv_out_if.source         frame_out
);

	localparam int FULL_W = pfsv_pkg::MAG_W + pfsv_pkg::RECIP_W;

	logic [FULL_W-1:0]                     quot_full;
	logic [pfsv_pkg::QUOT_W-1:0]           quot;
	logic [pfsv_pkg::QUOT_W-1:0]           quot_neg;
	logic signed [pfsv_pkg::SAMPLE_W-1:0]  sat;
	logic                                  valid_q;
	logic signed [pfsv_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                  last_q;

	always_comb begin
		quot_full = FULL_W'(up_data.mag) * FULL_W'(pfsv_pkg::RECIP);
		quot      = quot_full[FULL_W-1:pfsv_pkg::RECIP_SHIFT];
		quot_neg  = -quot;
		priority if (!up_data.neg && quot > pfsv_pkg::SAT_POS_LIMIT) begin
			sat = pfsv_pkg::SAT_MAX;
		end else if (up_data.neg && quot > pfsv_pkg::SAT_NEG_LIMIT) begin
			sat = pfsv_pkg::SAT_MIN;
		end else if (up_data.neg) begin
			sat = quot_neg[pfsv_pkg::SAMPLE_W-1:0];
		end else begin
			sat = quot[pfsv_pkg::SAMPLE_W-1:0];
		end
	end

	assign up_ready = !valid_q || frame_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			sample_q <= sat;
			last_q   <= up_data.last_frame;
		end
	end

	assign frame_out.valid          = valid_q;
	assign frame_out.left_sample    = sample_q;
	assign frame_out.right_sample   = sample_q;
	assign frame_out.last_frame_out = last_q;

endmodule

[hw/rtl/pcm_frame_to_stereo16_volume.sv]
// ----------------------------------------------------------------------------
// pcm_frame_to_stereo16_volume
// PCM frame to duplicated 16-bit stereo sample with percent volume
// ----------------------------------------------------------------------------
// usage:
//   frame_in carries one pcm frame per transaction: two raw little-endian
//   sample words and a last-frame mark. frame_out carries one transaction
//   per frame: the same scaled, saturated sample on left and right plus a
//   copy of the last-frame mark. cfg writes the width code (index 0), mono
//   select (index 1) and volume in percent (index 2); cfg is always ready
//   and should only be written while no frame is in flight.
// path: a frame passes the input register, gain register and result
//   register in that order before it shows on frame_out.
// throughput: one frame per cycle; all three registers advance together
//   when frame_out is ready.
// reset: pipeline empties, width code goes to 16-bit, stereo averaging,
//   volume 60.
// stall: each register holds while the next one is full and stalled, so
//   three frames can be buffered before frame_in.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_frame_to_stereo16_volume (
	input  logic       clk,
	input  logic       arst_n,
	pfsv_cfg_if.sink   cfg,
	pfsv_in_if.sink    frame_in,
	pfsv_out_if.source frame_out
);

	// configuration registers
	pfsv_pkg::width_code_t             width_code_q;
	logic                              mono_source_q;
	logic [pfsv_pkg::VOL_W-1:0]        gain_pct_q;
	pfsv_pkg::pfsv_cfg_t               cfg_val;

	// input register stage
	logic                              valid_s1;
	logic                              ready_s1;
	pfsv_pkg::pfsv_s1_t                data_s1;

	// gain to scale hand-off
	logic                              valid_s2;
	logic                              ready_s2;
	pfsv_pkg::pfsv_s2_t                data_s2;
	logic                              ready_s3;

	// register writes are always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q  <= pfsv_pkg::WIDTH_S16;
			mono_source_q <= 1'b0;
			gain_pct_q    <= pfsv_pkg::VOLUME_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pfsv_pkg::REG_SAMPLE_WIDTH: begin
					width_code_q <= pfsv_pkg::width_code_t'(cfg.data[1:0]);
				end
				pfsv_pkg::REG_MONO_SOURCE: begin
					mono_source_q <= cfg.data[0];
				end
				pfsv_pkg::REG_GAIN_PCT: begin
					gain_pct_q <= cfg.data[pfsv_pkg::VOL_W-1:0];
				end
				// index beyond the register list is dropped
				default: begin
				end
			endcase
		end
	end

	assign cfg_val.width_code  = width_code_q;
	assign cfg_val.mono_source = mono_source_q;
	assign cfg_val.gain_pct    = gain_pct_q;

	// input register, fills whenever it is empty or draining this cycle
	assign ready_s1       = !valid_s1 || ready_s2;
	assign frame_in.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && frame_in.valid) begin
			data_s1.first_sample_raw  <= frame_in.first_sample_raw;
			data_s1.second_sample_raw <= frame_in.second_sample_raw;
			data_s1.last_frame        <= frame_in.last_frame;
		end
	end

	// reduce, average and multiply by volume
	pfsv_gain u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_val  (cfg_val),
		.up_valid (valid_s1),
		.up_ready (ready_s2),
		.up_data  (data_s1),
		.dn_valid (valid_s2),
		.dn_ready (ready_s3),
		.dn_data  (data_s2)
	);

	// divide by one hundred, clamp, result register
	pfsv_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid_s2),
		.up_ready  (ready_s3),
		.up_data   (data_s2),
		.frame_out (frame_out)
	);

	// backpressure only reaches the input once every stage holds a frame
	`ASSERT_IMPLIES(a_full_when_blocked, clk, arst_n, !frame_in.ready, valid_s1 && valid_s2 && frame_out.valid, "input blocked with a pipeline bubble")

	// a stalled input register keeps its frame
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !ready_s1, valid_s1 && $stable(data_s1), "input register lost a stalled frame")

	// a stalled gain stage keeps its frame
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !ready_s3, valid_s2 && $stable(data_s2), "gain register lost a stalled frame")

	// both channels carry the same sample
	`ASSERT_IMPLIES(a_lr_equal, clk, arst_n, frame_out.valid, frame_out.left_sample == frame_out.right_sample, "left and right differ")

endmodule
